// ----- hw/rtl/rgbec_pkg.sv -----
`timescale 1ns / 1ps

package rgbec_pkg;

    // Sizing of the image statistics.
    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int DIST_FRAC_BITS  = 8;

    // Widths of the per-pair arithmetic.
    localparam int CH_W    = 8;
    localparam int SQ_W    = 2 * CH_W;
    localparam int S_W     = SQ_W + 2;
    localparam int RAD_W   = S_W + 2 * DIST_FRAC_BITS;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 1;

    // Widths of the image accumulation and normalisation.
    localparam int SUM_W     = ROOT_W + MAX_PIXELS_LOG2;
    localparam int CNT_W     = MAX_PIXELS_LOG2 + 1;
    localparam int SUM16_W   = SUM_W + 16 - DIST_FRAC_BITS;
    localparam int MEAN_W    = ROOT_W + 16 - DIST_FRAC_BITS;
    localparam int K_W       = 24;
    localparam int PROD_W    = MEAN_W + K_W;
    localparam int RND_W     = PROD_W + 1;
    localparam int SHIFT_W   = RND_W - 32;
    localparam int COST_W    = 17;
    localparam int DIV_CNT_W = $clog2(SUM16_W + 1);

    localparam logic [CNT_W-1:0]     CNT_LIMIT    = CNT_W'(1) << MAX_PIXELS_LOG2;
    localparam logic [K_W-1:0]       INV_DIAG_Q32 = K_W'(9724316);
    localparam logic [COST_W-1:0]    COST_ONE     = COST_W'(65536);
    localparam logic [RND_W-1:0]     ROUND_HALF   = RND_W'(1) << 31;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS    = DIV_CNT_W'(SUM16_W);

    // Data handed from one square-root cell to the next.
    typedef struct packed {
        logic              last;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } rgbec_root_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

// ----- hw/rtl/rgbec_if.sv -----
`timescale 1ns / 1ps

// Pixel-pair channel.
interface rgbec_pix_if import rgbec_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] first_red;
    logic [CH_W-1:0] first_green;
    logic [CH_W-1:0] first_blue;
    logic [CH_W-1:0] second_red;
    logic [CH_W-1:0] second_green;
    logic [CH_W-1:0] second_blue;
    logic            last_pixel;

    modport source (
        output valid, first_red, first_green, first_blue,
        output second_red, second_green, second_blue, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, first_red, first_green, first_blue,
        input  second_red, second_green, second_blue, last_pixel,
        output ready
    );
endinterface

// Image cost channel.
interface rgbec_cost_if import rgbec_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] normalized_cost;
    logic [CNT_W-1:0]  pixels_counted;
    logic              count_overflow;

    modport source (
        output valid, normalized_cost, pixels_counted, count_overflow,
        input  ready
    );
    modport sink (
        input  valid, normalized_cost, pixels_counted, count_overflow,
        output ready
    );
endinterface

// ----- hw/rtl/rgbec_root_cell.sv -----
`timescale 1ns / 1ps

// One digit of the integer square root: brings down two radicand bits and
// decides one root bit, then passes the partial result on.
module rgbec_root_cell import rgbec_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        up_valid,
    input  rgbec_root_t up_data,
    output logic        dn_valid,
    output rgbec_root_t dn_data
);

    logic                valid_reg;
    rgbec_root_t         data_reg;
    rgbec_root_t         data_next;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                take_bit;

    always_comb
    begin
        rem_sh   = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
        trial    = (REM_W+2)'({up_data.root, 2'b01});
        take_bit = (rem_sh >= trial);

        data_next.last = up_data.last;
        data_next.rad  = up_data.rad << 2;
        if (take_bit)
        begin
            data_next.rem = REM_W'(rem_sh - trial);
        end
        else
        begin
            data_next.rem = rem_sh[REM_W-1:0];
        end
        data_next.root = {up_data.root[ROOT_W-2:0], take_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- hw/rtl/rgbec_divider.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient is held
// until it is taken.
module rgbec_divider import rgbec_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM16_W-1:0] dividend,
    input  logic [CNT_W-1:0]   divisor,
    input  logic               take,
    output logic               busy,
    output logic               done,
    output logic [SUM16_W-1:0] quotient
);

    div_state_t           state_reg;
    div_state_t           state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM16_W-1:0]   dvd_reg;
    logic [SUM16_W-1:0]   quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsr_reg;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       diff;
    logic                 ge;

    assign rem_sh = {rem_reg, dvd_reg[SUM16_W-1]};
    assign ge     = (rem_sh >= {1'b0, dsr_reg});
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                done = 1'b1;
                if (take)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DIV_IDLE && start)
            begin
                cnt_reg <= DIV_STEPS;
            end
            else if (state_reg == DIV_RUN)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (state_reg == DIV_RUN)
        begin
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[SUM16_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign quotient = quo_reg;

`ifndef NO_ASSERTIONS
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(SUM16_W + 1) done)
        else $error("divider did not finish in the expected number of cycles");

    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !take) |=> (done && $stable(quotient)))
        else $error("divider result changed before it was taken");
`endif

endmodule

// ----- hw/rtl/rgb_euclidean_image_cost.sv -----
`timescale 1ns / 1ps
// An accepted pair passes the front register and the chain of root cells before
// it is accumulated; the last pair of an image then passes the bit-serial divider,
// the scaling register and the output register on its way to its cost item.
// Throughput: one pixel pair per cycle; a last pair waits at the end of the
// root chain while the divider still holds the previous image, dividing or
// waiting for its quotient to be taken.
// Reset: asynchronous, active low; clears all valid bits, sum, count and flag.
//
// Each item carries two RGB pixels. A front stage forms the sum of squared
// channel differences, and a chain of identical cells then extracts the
// distance, one root bit per cell, with the item moving one cell per cycle.
// At the end of the chain the distances are summed and pairs counted. The
// last item of an image hands sum and count to the divider, and the mean is
// scaled by 1/(255*sqrt(3)) with one multiply, rounded and saturated.

module rgb_euclidean_image_cost import rgbec_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    rgbec_pix_if.sink     pixels,
    rgbec_cost_if.source  costs
);

    // The whole root chain moves together; it stops only when a last pair
    // has reached its end and the divider is still busy with the previous
    // image.
    logic advance;
    logic fire;
    logic div_start;
    logic div_busy;
    logic div_done;
    logic div_take;
    logic [SUM16_W-1:0] div_quo;

    // Front stage: squared colour distance.
    logic [CH_W-1:0] d_red;
    logic [CH_W-1:0] d_green;
    logic [CH_W-1:0] d_blue;
    logic [S_W-1:0]  s_value;
    logic            front_valid_reg;
    logic            front_last_reg;
    logic [S_W-1:0]  front_s_reg;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        d_red   = abs_diff(pixels.first_red,   pixels.second_red);
        d_green = abs_diff(pixels.first_green, pixels.second_green);
        d_blue  = abs_diff(pixels.first_blue,  pixels.second_blue);
        s_value = S_W'(SQ_W'(d_red) * SQ_W'(d_red))
                + S_W'(SQ_W'(d_green) * SQ_W'(d_green))
                + S_W'(SQ_W'(d_blue) * SQ_W'(d_blue));
    end

    assign pixels.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= pixels.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_last_reg <= pixels.last_pixel;
            front_s_reg    <= s_value;
        end
    end

    // Square-root chain. The radicand is the squared distance shifted up by
    // twice the fraction bits, so the root carries DIST_FRAC_BITS fraction
    // bits.
    logic        chain_valid [ROOT_W+1];
    rgbec_root_t chain_data  [ROOT_W+1];

    always_comb
    begin
        chain_valid[0]     = front_valid_reg;
        chain_data[0].last = front_last_reg;
        chain_data[0].rad  = RAD_W'(front_s_reg) << (2 * DIST_FRAC_BITS);
        chain_data[0].rem  = '0;
        chain_data[0].root = '0;
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_root
        rgbec_root_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (advance),
            .up_valid (chain_valid[i]),
            .up_data  (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_data  (chain_data[i+1])
        );
    end

    // Image accumulation at the end of the chain.
    logic              tail_valid;
    rgbec_root_t       tail;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic              at_limit;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_next;

    assign tail_valid = chain_valid[ROOT_W];
    assign tail       = chain_data[ROOT_W];
    assign advance    = !(tail_valid && tail.last && div_busy);
    assign fire       = tail_valid && advance;
    assign div_start  = fire && tail.last;

    // A pair that arrives while the count sits at its limit is dropped and
    // only marks the overflow.
    always_comb
    begin
        at_limit = (count_reg == CNT_LIMIT);
        if (at_limit)
        begin
            sum_next   = sum_reg;
            count_next = count_reg;
        end
        else
        begin
            sum_next   = sum_reg + SUM_W'(tail.root);
            count_next = count_reg + CNT_W'(1);
        end
        ovf_next = ovf_reg | at_limit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (tail.last)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Image totals that travel alongside the division.
    logic [CNT_W-1:0] meta_cnt_reg;
    logic             meta_ovf_reg;
    logic             meta_zero_reg;

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            meta_cnt_reg  <= count_next;
            meta_ovf_reg  <= ovf_next;
            meta_zero_reg <= (count_next == '0);
        end
    end

    rgbec_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (SUM16_W'(sum_next) << (16 - DIST_FRAC_BITS)),
        .divisor  (count_next),
        .take     (div_take),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Scaling stage: mean times round(2^32 / (255*sqrt(3))). The mean never
    // exceeds the largest distance, so its upper quotient bits are zero.
    logic              mul_valid_reg;
    logic [PROD_W-1:0] mul_prod_reg;
    logic [CNT_W-1:0]  mul_cnt_reg;
    logic              mul_ovf_reg;
    logic              mul_zero_reg;
    logic              out_load;

    assign out_load = mul_valid_reg && (!costs.valid || costs.ready);
    assign div_take = div_done && (!mul_valid_reg || out_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (div_take)
        begin
            mul_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            mul_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_take)
        begin
            mul_prod_reg <= PROD_W'(div_quo[MEAN_W-1:0]) * PROD_W'(INV_DIAG_Q32);
            mul_cnt_reg  <= meta_cnt_reg;
            mul_ovf_reg  <= meta_ovf_reg;
            mul_zero_reg <= meta_zero_reg;
        end
    end

    // Output register: round to nearest, saturate at 1.0, and force zero for
    // an image with no counted pairs.
    logic [RND_W-1:0]   rounded;
    logic [SHIFT_W-1:0] scaled;
    logic [COST_W-1:0]  cost_value;
    logic               out_valid_reg;
    logic [COST_W-1:0]  out_cost_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_ovf_reg;

    always_comb
    begin
        rounded = RND_W'(mul_prod_reg) + ROUND_HALF;
        scaled  = rounded[RND_W-1:32];
        if (mul_zero_reg)
        begin
            cost_value = '0;
        end
        else if (scaled > SHIFT_W'(COST_ONE))
        begin
            cost_value = COST_ONE;
        end
        else
        begin
            cost_value = scaled[COST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (costs.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cost_reg <= cost_value;
            out_cnt_reg  <= mul_cnt_reg;
            out_ovf_reg  <= mul_ovf_reg;
        end
    end

    assign costs.valid           = out_valid_reg;
    assign costs.normalized_cost = out_cost_reg;
    assign costs.pixels_counted  = out_cnt_reg;
    assign costs.count_overflow  = out_ovf_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_LIMIT)
        else $error("pixel count passed its limit");

    a_cost_bound: assert property (@(posedge clk) disable iff (!rst_n)
        costs.valid |-> (costs.normalized_cost <= COST_ONE))
        else $error("cost above 1.0 on the output");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        costs.valid |-> (costs.pixels_counted != '0))
        else $error("cost item for an image with no counted pairs");
`endif

endmodule

// ----- bench/rgbec_cost_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the image statistics and
// compares every cost item with the oldest outstanding expectation.
module rgbec_cost_checker import rgbec_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    rgbec_pix_if   pix,
    rgbec_cost_if  cost,
    output int     mismatches,
    output int     pending,
    output int     pairs_seen,
    output int     images_checked,
    output int     saturated_images
);

    localparam longint unsigned PAIR_LIMIT     = 64'd1 << MAX_PIXELS_LOG2;
    localparam longint unsigned DIAG_RECIP_Q32 = 64'd9724316;
    localparam longint unsigned FULL_SCALE     = 64'd65536;
    localparam int              REPORT_MAX     = 10;

    typedef struct packed {
        logic [COST_W-1:0] normalized_cost;
        logic [CNT_W-1:0]  pixels_counted;
        logic              count_overflow;
    } image_cost_t;

    image_cost_t       expected_costs[$];
    longint unsigned   distance_total;
    logic [CNT_W-1:0]  pair_count;
    logic              limit_hit;
    int                reports;

    function automatic longint unsigned channel_sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
        longint unsigned d;
        d = (a >= b) ? longint'(a - b) : longint'(b - a);
        return d * d;
    endfunction

    // Distance with DIST_FRAC_BITS fraction bits, truncated: the largest
    // root whose square does not exceed the scaled sum of squares.
    function automatic longint unsigned pair_distance(
        logic [CH_W-1:0] fr, logic [CH_W-1:0] fg, logic [CH_W-1:0] fb,
        logic [CH_W-1:0] sr, logic [CH_W-1:0] sg, logic [CH_W-1:0] sb);
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        radicand = (channel_sq(fr, sr) + channel_sq(fg, sg) + channel_sq(fb, sb))
                   << (2 * DIST_FRAC_BITS);
        root = 0;
        for (int b = 24; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [COST_W-1:0] image_cost(longint unsigned total,
                                                     longint unsigned pairs);
        longint unsigned mean_q16;
        longint unsigned scaled;
        if (pairs == 0)
            return '0;
        mean_q16 = (total << (16 - DIST_FRAC_BITS)) / pairs;
        scaled   = (mean_q16 * DIAG_RECIP_Q32 + (64'd1 << 31)) >> 32;
        if (scaled > FULL_SCALE)
            scaled = FULL_SCALE;
        return COST_W'(scaled);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        image_cost_t want;
        image_cost_t got;
        if (!rst_n)
        begin
            distance_total   = 0;
            pair_count       = '0;
            limit_hit        = 1'b0;
            expected_costs.delete();
            reports          = 0;
            mismatches       = 0;
            pending          = 0;
            pairs_seen       = 0;
            images_checked   = 0;
            saturated_images = 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                pairs_seen++;
                if (pair_count >= PAIR_LIMIT)
                    limit_hit = 1'b1;
                else
                begin
                    distance_total += pair_distance(pix.first_red, pix.first_green,
                                                    pix.first_blue, pix.second_red,
                                                    pix.second_green, pix.second_blue);
                    pair_count++;
                end
                if (pix.last_pixel)
                begin
                    want.normalized_cost = image_cost(distance_total, pair_count);
                    want.pixels_counted  = pair_count;
                    want.count_overflow  = limit_hit;
                    expected_costs.push_back(want);
                    distance_total = 0;
                    pair_count     = '0;
                    limit_hit      = 1'b0;
                end
            end

            if (cost.valid && cost.ready)
            begin
                got.normalized_cost = cost.normalized_cost;
                got.pixels_counted  = cost.pixels_counted;
                got.count_overflow  = cost.count_overflow;
                if (expected_costs.size() == 0)
                begin
                    mismatches++;
                    if (reports < REPORT_MAX)
                    begin
                        reports++;
                        $display("%0t: cost item with nothing expected:", $time);
                        $display("    cost %0d count %0d overflow %0b",
                                 got.normalized_cost, got.pixels_counted,
                                 got.count_overflow);
                    end
                end
                else
                begin
                    want = expected_costs.pop_front();
                    images_checked++;
                    if (want.count_overflow)
                        saturated_images++;
                    if (got.normalized_cost !== want.normalized_cost ||
                        got.pixels_counted  !== want.pixels_counted  ||
                        got.count_overflow  !== want.count_overflow)
                    begin
                        mismatches++;
                        if (reports < REPORT_MAX)
                        begin
                            reports++;
                            $display("%0t: cost mismatch: expected cost %0d count %0d overflow %0b",
                                     $time, want.normalized_cost, want.pixels_counted,
                                     want.count_overflow);
                            $display("    got cost %0d count %0d overflow %0b",
                                     got.normalized_cost, got.pixels_counted,
                                     got.count_overflow);
                        end
                    end
                end
            end
            pending = expected_costs.size();
        end
    end

endmodule

// ----- bench/tb_rgb_euclidean_image_cost.sv -----
`timescale 1ns / 1ps

// Top level of the image cost bench. It makes the clock, the single reset,
// the pixel-pair stimulus and the back-pressure on the cost channel, and it
// gives the verdict. All prediction and comparison lives in the checker that
// sits beside the block and watches both channels.
module tb_rgb_euclidean_image_cost;
    import rgbec_pkg::*;

    // Size of the random part, in pixel pairs.
    localparam int RANDOM_PAIRS   = 1650;
    // Length of the deliberate output hold-off, in cycles. Past the root
    // chain the block holds at most three finished images (output, scaling
    // and divider), so a run of one-pair images backs up through the divider
    // and the root chain well inside this stretch.
    localparam int LONG_HOLD      = 400;
    localparam int PRESSURE_IMGS  = 40;
    // Cycles allowed after the last expected item: root chain plus divider,
    // with room to spare.
    localparam int DRAIN_CYCLES   = 160;
    localparam int IDLE_MAX       = 12;

    logic clk;
    logic rst_n;

    rgbec_pix_if  pix_ch ();
    rgbec_cost_if cost_ch ();

    int  mismatches;
    int  pending;
    int  pairs_seen;
    int  images_checked;
    int  saturated_images;

    // Set by the stimulus to ask the receiver for the long hold-off; the
    // receiver clears it once the hold-off has run its course.
    bit  hold_req;
    // While set, the sender offers items back to back.
    bit  sender_quiet;
    int  random_sent;

    rgb_euclidean_image_cost dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pix_ch),
        .costs  (cost_ch)
    );

    rgbec_cost_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .pix              (pix_ch),
        .cost             (cost_ch),
        .mismatches       (mismatches),
        .pending          (pending),
        .pairs_seen       (pairs_seen),
        .images_checked   (images_checked),
        .saturated_images (saturated_images)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Safety net: the slowest correct run, with every pair closing an image
    // and both sides idling as long as they can, needs under a fifth of this.
    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d cost item(s) still expected.", pending);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int idle_cycles(bit quiet);
        return quiet ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // Offers one pixel pair after a random idle gap and returns once it has
    // been accepted. Valid is only lowered in a later step than it was
    // raised, so each step sees at most one assignment to it.
    task automatic send_pair(input logic [CH_W-1:0] fr, input logic [CH_W-1:0] fg,
                             input logic [CH_W-1:0] fb, input logic [CH_W-1:0] sr,
                             input logic [CH_W-1:0] sg, input logic [CH_W-1:0] sb,
                             input logic last);
        int gap;
        gap = idle_cycles(sender_quiet);
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.first_red    <= fr;
        pix_ch.first_green  <= fg;
        pix_ch.first_blue   <= fb;
        pix_ch.second_red   <= sr;
        pix_ch.second_green <= sg;
        pix_ch.second_blue  <= sb;
        pix_ch.last_pixel   <= last;
        pix_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!pix_ch.ready);
    endtask

    function automatic logic [CH_W-1:0] nearby(logic [CH_W-1:0] base);
        int v;
        v = int'(base) + $urandom_range(0, 8) - 4;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return CH_W'(v);
    endfunction

    function automatic logic [CH_W-1:0] extreme();
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endfunction

    // A random pair: mostly fully random channels, some nearly equal pixels
    // (small distances, where the root's fraction bits matter most), and some
    // made only of the channel extremes.
    task automatic send_random_pair(input logic last);
        logic [CH_W-1:0] fr, fg, fb, sr, sg, sb;
        int              mode;
        fr   = CH_W'($urandom);
        fg   = CH_W'($urandom);
        fb   = CH_W'($urandom);
        sr   = CH_W'($urandom);
        sg   = CH_W'($urandom);
        sb   = CH_W'($urandom);
        mode = $urandom_range(0, 3);
        if (mode == 2)
        begin
            sr = nearby(fr);
            sg = nearby(fg);
            sb = nearby(fb);
        end
        else if (mode == 3)
        begin
            fr = extreme();
            fg = extreme();
            fb = extreme();
            sr = extreme();
            sg = extreme();
            sb = extreme();
        end
        send_pair(fr, fg, fb, sr, sg, sb, last);
    endtask

    // One image of the given number of random pairs, the final one marked.
    task automatic send_random_image(input int pairs);
        for (int i = 0; i < pairs; i++)
            send_random_pair(i == pairs - 1);
    endtask

    // Receiver: before each cost item it draws an idle gap, now and then
    // running a stretch with no idling at all. The long hold-off is counted
    // here, in cycles, while the sender keeps offering items.
    initial
    begin
        int gap;
        int quiet_left;
        quiet_left    = 0;
        cost_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                cost_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (quiet_left == 0 && $urandom_range(0, 4) == 0)
                    quiet_left = $urandom_range(5, 20);
                gap = idle_cycles(quiet_left > 0);
                if (quiet_left > 0)
                    quiet_left--;
                if (gap > 0)
                begin
                    cost_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                cost_ch.ready <= 1'b1;
                do
                    @(posedge clk);
                while (!(cost_ch.valid && cost_ch.ready) && !hold_req);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int img_len;
        hold_req     = 1'b0;
        sender_quiet = 1'b0;
        random_sent  = 0;

        // Every input of the block starts at a known value.
        rst_n               <= 1'b0;
        pix_ch.valid        <= 1'b0;
        pix_ch.first_red    <= '0;
        pix_ch.first_green  <= '0;
        pix_ch.first_blue   <= '0;
        pix_ch.second_red   <= '0;
        pix_ch.second_green <= '0;
        pix_ch.second_blue  <= '0;
        pix_ch.last_pixel   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Identical pixels give a zero cost; opposite corners
        // of the colour cube give the largest distance, which lands on or at
        // the saturation of the cost.
        send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
        send_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // A full difference on one channel at a time.
        send_pair(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_pair(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        // A three-pair image with alternating bit patterns and tiny steps.
        send_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
        send_pair(8'h01, 8'h02, 8'h03, 8'h01, 8'h02, 8'h03, 1'b0);
        send_pair(8'h80, 8'h7F, 8'h00, 8'h7F, 8'h80, 8'h01, 1'b1);
        // Smallest non-zero distance, averaged with a zero one.
        send_pair(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        // Four pairs all at the largest distance, to hit the cost ceiling
        // through the mean rather than through a single pair.
        send_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pair(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_pair(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);

        // Random images, mostly short with the occasional longer one. Some
        // images are sent with no idling so the pipeline runs full.
        while (random_sent < RANDOM_PAIRS)
        begin
            if (random_sent >= RANDOM_PAIRS / 2 && random_sent < RANDOM_PAIRS / 2 + 50)
            begin
                // Back-pressure: one-pair images sent back to back while the
                // receiver holds off, so finished costs pile up, the divider
                // blocks and the input stalls.
                hold_req     = 1'b1;
                sender_quiet = 1'b1;
                for (int i = 0; i < PRESSURE_IMGS; i++)
                    send_random_pair(1'b1);
                random_sent += PRESSURE_IMGS + 50;
            end
            sender_quiet = ($urandom_range(0, 3) == 0);
            img_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
            send_random_image(img_len);
            random_sent += img_len;
        end

        // A short tail of images with ordinary idling.
        sender_quiet = 1'b0;
        send_random_image(2);
        send_random_image(1);

        pix_ch.valid <= 1'b0;

        // Let the checker see the final acceptance, then wait for every
        // outstanding cost and a little longer for anything unexpected.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pixel pairs in %0d images, including one long output hold-off.",
                 pairs_seen, images_checked);
        $display("%0d cost item(s) flagged a count overflow; %0d mismatch(es).",
                 saturated_images, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rgbec_pkg.sv
hw/rtl/rgbec_if.sv
hw/rtl/rgbec_root_cell.sv
hw/rtl/rgbec_divider.sv
hw/rtl/rgb_euclidean_image_cost.sv
bench/rgbec_cost_checker.sv
bench/tb_rgb_euclidean_image_cost.sv
